[hdl/lidar_scan_obstacle_segmenter_assert.svh]
// ----------------------------------------------------------------------------
// lidar_scan_obstacle_segmenter_assert.svh
// Assertion macros for the segmenter top level.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_OBSTACLE_SEGMENTER_ASSERT_SVH
`define LIDAR_SCAN_OBSTACLE_SEGMENTER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define LSOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LSOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lsos_pkg.sv]
// ----------------------------------------------------------------------------
// lsos_pkg
// Types, constants and command/status structs of the obstacle segmenter.
// ----------------------------------------------------------------------------
package lsos_pkg;

    localparam int SCAN_POINTS = 1024;
    localparam int ADDR_W      = $clog2(SCAN_POINTS);
    localparam int DIST_W      = 16;
    localparam int ANGLE_W     = 10;
    localparam int SUM_W       = 26;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 2;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [DIST_W-1:0]    dist_t;
    typedef logic [ANGLE_W-1:0]   angle_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam sum_t   SUM_MAX   = '1;
    localparam count_t COUNT_MAX = '1;
    localparam count_t COUNT_ONE = count_t'(1);
    localparam dist_t  FAR_DIST  = '1;

    localparam cfg_idx_t REG_MIN_DIST  = 2'd0;
    localparam cfg_idx_t REG_START_MAX = 2'd1;
    localparam cfg_idx_t REG_JUMP      = 2'd2;

    localparam dist_t MIN_DIST_RST  = 16'd20;
    localparam dist_t START_MAX_RST = 16'd5600;
    localparam dist_t JUMP_RST      = 16'd300;

    localparam logic OP_MEASURE  = 1'b0;
    localparam logic OP_BG_WRITE = 1'b1;

    // floor(d * 19 / 20) is (d * BG_SCALE_MUL) >> BG_MUL_W for every 16-bit d
    localparam int                  BG_MUL_W     = 25;
    localparam int                  BG_PROD_W    = DIST_W + BG_MUL_W;
    localparam logic [BG_MUL_W-1:0] BG_SCALE_MUL = BG_MUL_W'(31876718);

    typedef struct packed {
        logic load;
        logic prep;
        logic div_start;
        logic fin;
        logic bg_write;
        logic clear_step;
    } lsos_cmd_t;

    typedef struct packed {
        logic op;
        logic prep_valid;
        logic div_done;
        logic out_free;
        logic clear_last;
    } lsos_sts_t;

    function automatic logic in_range(angle_t a);
        return int'(a) < SCAN_POINTS;
    endfunction

endpackage

[hdl/lsos_in_if.sv]
// ----------------------------------------------------------------------------
// lsos_in_if
// Sample channel: one range sample or background write per transfer.
// ----------------------------------------------------------------------------
interface lsos_in_if;
    logic            valid;
    logic            ready;
    logic            operation;
    lsos_pkg::angle_t angle_index;
    lsos_pkg::dist_t  distance_mm;
    logic            first_in_scan;
    logic            last_in_scan;

    modport source (
        output valid, operation, angle_index, distance_mm, first_in_scan, last_in_scan,
        input  ready
    );
    modport sink (
        input  valid, operation, angle_index, distance_mm, first_in_scan, last_in_scan,
        output ready
    );
endinterface

[hdl/lsos_out_if.sv]
// ----------------------------------------------------------------------------
// lsos_out_if
// Result channel: per-sample status and an optional obstacle record.
// ----------------------------------------------------------------------------
interface lsos_out_if;
    logic             valid;
    logic             ready;
    logic             sample_valid;
    logic             inside_obstacle;
    logic             obstacle_done;
    lsos_pkg::angle_t obstacle_first_index;
    lsos_pkg::angle_t obstacle_last_index;
    lsos_pkg::dist_t  obstacle_mean_mm;

    modport source (
        output valid, sample_valid, inside_obstacle, obstacle_done,
               obstacle_first_index, obstacle_last_index, obstacle_mean_mm,
        input  ready
    );
    modport sink (
        input  valid, sample_valid, inside_obstacle, obstacle_done,
               obstacle_first_index, obstacle_last_index, obstacle_mean_mm,
        output ready
    );
endinterface

[hdl/lsos_cfg_if.sv]
// ----------------------------------------------------------------------------
// lsos_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lsos_cfg_if;
    logic               valid;
    logic               ready;
    lsos_pkg::cfg_idx_t index;
    lsos_pkg::dist_t    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/lsos_ram.sv]
// ----------------------------------------------------------------------------
// lsos_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lsos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/lsos_div.sv]
// ----------------------------------------------------------------------------
// lsos_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsos_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lsos_pkg::sum_t   dividend,
    input  lsos_pkg::count_t divisor,
    output logic             done,
    output lsos_pkg::sum_t   quotient
);

    localparam int CNT_W = $clog2(lsos_pkg::SUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lsos_pkg::SUM_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    lsos_pkg::sum_t         dvd_reg, dvd_next;
    lsos_pkg::count_t       dsr_reg, dsr_next;
    lsos_pkg::count_t       rem_reg, rem_next;
    logic [lsos_pkg::COUNT_W:0] trial;
    logic [lsos_pkg::COUNT_W:0] diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[lsos_pkg::SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[lsos_pkg::COUNT_W-1:0];
                dvd_next = {dvd_reg[lsos_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[lsos_pkg::COUNT_W-1:0];
                dvd_next = {dvd_reg[lsos_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[hdl/lsos_ctrl.sv]
// ----------------------------------------------------------------------------
// lsos_ctrl
// Sequencer: background clear, item load, divide, update and write-back.
// ----------------------------------------------------------------------------
module lsos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lsos_pkg::lsos_sts_t sts,
    output lsos_pkg::lsos_cmd_t cmd,
    output logic                in_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (sts.op == lsos_pkg::OP_BG_WRITE)
                begin
                    cmd.bg_write = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.prep = 1'b1;
                    if (sts.prep_valid)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/lsos_datapath.sv]
// ----------------------------------------------------------------------------
// lsos_datapath
// Sample conditioning, background store, running mean and obstacle record.
// ----------------------------------------------------------------------------
module lsos_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lsos_pkg::lsos_cmd_t cmd,
    output lsos_pkg::lsos_sts_t sts,
    input  logic                in_operation,
    input  lsos_pkg::angle_t    in_angle_index,
    input  lsos_pkg::dist_t     in_distance_mm,
    input  logic                in_first_in_scan,
    input  logic                in_last_in_scan,
    input  logic                cfg_we,
    input  lsos_pkg::cfg_idx_t  cfg_index,
    input  lsos_pkg::dist_t     cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_sample_valid,
    output logic                out_inside_obstacle,
    output logic                out_obstacle_done,
    output lsos_pkg::angle_t    out_obstacle_first_index,
    output lsos_pkg::angle_t    out_obstacle_last_index,
    output lsos_pkg::dist_t     out_obstacle_mean_mm
);

    // item
    logic             op_reg;
    lsos_pkg::angle_t angle_reg;
    lsos_pkg::dist_t  dist_reg;
    logic             first_reg;
    logic             last_reg;

    // configuration and scan state
    lsos_pkg::dist_t  min_reg;
    lsos_pkg::dist_t  jump_reg;
    lsos_pkg::dist_t  far_reg;
    lsos_pkg::sum_t   sum_reg, sum_next;
    lsos_pkg::count_t count_reg, count_next;
    lsos_pkg::dist_t  prior_reg;
    logic             inobs_reg, inobs_next;
    lsos_pkg::angle_t seg_reg, seg_next;

    // conditioned sample
    logic             valid_reg;
    lsos_pkg::dist_t  v_reg;
    logic             isbg_reg;

    lsos_pkg::addr_t  clr_reg;

    logic             out_valid_reg;
    logic             sample_valid_reg;
    logic             inside_reg;
    logic             done_reg;
    lsos_pkg::angle_t rec_first_reg;
    lsos_pkg::angle_t rec_last_reg;
    lsos_pkg::dist_t  rec_mean_reg;

    lsos_pkg::dist_t  ram_rdata;
    logic             ram_we;
    lsos_pkg::addr_t  ram_addr;
    lsos_pkg::dist_t  ram_wdata;

    logic             div_done;
    lsos_pkg::sum_t   quotient;
    lsos_pkg::sum_t   div_dividend;
    lsos_pkg::count_t div_divisor;

    logic             raise;
    logic             zero_in;
    logic             prep_valid;
    lsos_pkg::dist_t  v_raw;
    lsos_pkg::dist_t  bg_eff;
    logic             isbg_p;
    lsos_pkg::dist_t  v_clamp;
    lsos_pkg::sum_t   sum_eff;
    lsos_pkg::count_t count_eff;
    logic [lsos_pkg::BG_PROD_W-1:0] bg_prod;
    lsos_pkg::dist_t  bg_scaled;

    lsos_pkg::dist_t  pm;
    lsos_pkg::dist_t  dif;
    logic             jump;
    logic             done_next;

    function automatic logic acc_ok(lsos_pkg::sum_t s, lsos_pkg::count_t c,
                                    lsos_pkg::dist_t v);
        return (c < lsos_pkg::COUNT_MAX) &&
               (({1'b0, s} + {11'd0, v}) <= {1'b0, lsos_pkg::SUM_MAX});
    endfunction

    lsos_ram #(
        .WIDTH (lsos_pkg::DIST_W),
        .DEPTH (lsos_pkg::SCAN_POINTS)
    ) u_bg_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.load),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lsos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign ram_we    = cmd.clear_step || (cmd.bg_write && lsos_pkg::in_range(angle_reg));
    assign ram_wdata = cmd.clear_step ? lsos_pkg::FAR_DIST : bg_scaled;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_addr = clr_reg;
        end
        else if (cmd.bg_write)
        begin
            ram_addr = lsos_pkg::addr_t'(angle_reg);
        end
        else
        begin
            ram_addr = lsos_pkg::addr_t'(in_angle_index);
        end
    end

    // sample conditioning
    always_comb
    begin
        raise      = dist_reg > far_reg;
        zero_in    = dist_reg == '0;
        prep_valid = raise || zero_in || (dist_reg >= min_reg);
        v_raw      = (zero_in && !raise) ? far_reg : dist_reg;
        bg_eff     = lsos_pkg::in_range(angle_reg) ? ram_rdata : lsos_pkg::FAR_DIST;
        isbg_p     = v_raw >= bg_eff;
        v_clamp    = isbg_p ? bg_eff : v_raw;
        if (first_reg)
        begin
            sum_eff   = prep_valid ? lsos_pkg::sum_t'(bg_eff) : '0;
            count_eff = lsos_pkg::COUNT_ONE;
        end
        else
        begin
            sum_eff   = sum_reg;
            count_eff = count_reg;
        end
        bg_prod = {{lsos_pkg::BG_MUL_W{1'b0}}, dist_reg}
                * {{lsos_pkg::DIST_W{1'b0}}, lsos_pkg::BG_SCALE_MUL};
        bg_scaled    = bg_prod[lsos_pkg::BG_PROD_W-1 -: lsos_pkg::DIST_W];
        div_dividend = sum_eff;
        div_divisor  = count_eff;
    end

    // segment update
    always_comb
    begin
        pm         = quotient[lsos_pkg::DIST_W-1:0];
        dif        = (pm >= v_reg) ? (pm - v_reg) : (v_reg - pm);
        jump       = dif >= jump_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        inobs_next = inobs_reg;
        seg_next   = seg_reg;
        done_next  = 1'b0;
        if (valid_reg)
        begin
            if (inobs_next)
            begin
                if (jump || last_reg || isbg_reg)
                begin
                    done_next  = 1'b1;
                    sum_next   = lsos_pkg::sum_t'(v_reg);
                    count_next = lsos_pkg::COUNT_ONE;
                    inobs_next = 1'b0;
                end
                else if (acc_ok(sum_next, count_next, v_reg))
                begin
                    sum_next   = sum_next + lsos_pkg::sum_t'(v_reg);
                    count_next = count_next + lsos_pkg::COUNT_ONE;
                end
            end
            if (!inobs_next)
            begin
                if (jump && !isbg_reg)
                begin
                    sum_next   = lsos_pkg::sum_t'(v_reg);
                    count_next = lsos_pkg::COUNT_ONE;
                    seg_next   = angle_reg;
                    inobs_next = 1'b1;
                end
                else if (acc_ok(sum_next, count_next, v_reg))
                begin
                    sum_next   = sum_next + lsos_pkg::sum_t'(v_reg);
                    count_next = count_next + lsos_pkg::COUNT_ONE;
                end
            end
        end
        else if (inobs_reg && last_reg)
        begin
            done_next  = 1'b1;
            inobs_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= lsos_pkg::MIN_DIST_RST;
            jump_reg      <= lsos_pkg::JUMP_RST;
            far_reg       <= lsos_pkg::START_MAX_RST;
            sum_reg       <= '0;
            count_reg     <= lsos_pkg::COUNT_ONE;
            prior_reg     <= '0;
            inobs_reg     <= 1'b0;
            seg_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + lsos_pkg::addr_t'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lsos_pkg::REG_MIN_DIST:
                    begin
                        min_reg <= cfg_data;
                    end
                    lsos_pkg::REG_START_MAX:
                    begin
                        far_reg <= cfg_data;
                    end
                    lsos_pkg::REG_JUMP:
                    begin
                        jump_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.prep)
            begin
                if (raise)
                begin
                    far_reg <= dist_reg;
                end
                sum_reg   <= sum_eff;
                count_reg <= count_eff;
                if (first_reg)
                begin
                    prior_reg <= '0;
                    inobs_reg <= 1'b0;
                    seg_reg   <= '0;
                end
            end
            if (cmd.fin)
            begin
                sum_reg       <= sum_next;
                count_reg     <= count_next;
                inobs_reg     <= inobs_next;
                seg_reg       <= seg_next;
                if (valid_reg)
                begin
                    prior_reg <= pm;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_operation;
            angle_reg <= in_angle_index;
            dist_reg  <= in_distance_mm;
            first_reg <= in_first_in_scan;
            last_reg  <= in_last_in_scan;
        end
        if (cmd.prep)
        begin
            valid_reg <= prep_valid;
            v_reg     <= v_clamp;
            isbg_reg  <= isbg_p;
        end
        if (cmd.fin)
        begin
            sample_valid_reg <= valid_reg;
            inside_reg       <= inobs_next;
            done_reg         <= done_next;
            rec_first_reg    <= done_next ? seg_reg : '0;
            rec_last_reg     <= done_next ? (angle_reg - lsos_pkg::angle_t'(1)) : '0;
            rec_mean_reg     <= done_next ? (valid_reg ? pm : prior_reg) : '0;
        end
    end

    assign sts.op         = op_reg;
    assign sts.prep_valid = prep_valid;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.clear_last = clr_reg == lsos_pkg::addr_t'(lsos_pkg::SCAN_POINTS - 1);

    assign out_valid                = out_valid_reg;
    assign out_sample_valid         = sample_valid_reg;
    assign out_inside_obstacle      = inside_reg;
    assign out_obstacle_done        = done_reg;
    assign out_obstacle_first_index = rec_first_reg;
    assign out_obstacle_last_index  = rec_last_reg;
    assign out_obstacle_mean_mm     = rec_mean_reg;

endmodule

[hdl/lidar_scan_obstacle_segmenter.sv]
// A valid measure sample runs through these steps before the next transfer
// is accepted: its acceptance, conditioning against its background distance
// read from the on-chip store, the bit-serial divider that forms the running
// mean (26 quotient steps and a registered done flag), and the update of the
// segment with the load of the result register. An invalid sample skips the
// divider. A background write forms its 95 percent scaling with one constant
// multiplication and gives no result. The update waits while the previous
// result is still held in the output register, so receiver stalls hold up
// the next transfer. After reset the block fills all 1024 entries of the
// background store with 65535 and accepts no sample meanwhile; configuration
// writes are taken at any time. A finished result waits in an output register
// while the next sample is accepted.
// ----------------------------------------------------------------------------
// lidar_scan_obstacle_segmenter
// Top level: controller, datapath and channel hookup.
// ----------------------------------------------------------------------------
`include "lidar_scan_obstacle_segmenter_assert.svh"

module lidar_scan_obstacle_segmenter (
    input  logic      clk,
    input  logic      rst_n,
    lsos_in_if.sink   sample_in,
    lsos_out_if.source result,
    lsos_cfg_if.sink  cfg
);

    lsos_pkg::lsos_cmd_t cmd;
    lsos_pkg::lsos_sts_t sts;
    logic                in_ready;

    assign sample_in.ready = in_ready;
    assign cfg.ready       = 1'b1;

    lsos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    lsos_datapath u_dp (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cmd                      (cmd),
        .sts                      (sts),
        .in_operation             (sample_in.operation),
        .in_angle_index           (sample_in.angle_index),
        .in_distance_mm           (sample_in.distance_mm),
        .in_first_in_scan         (sample_in.first_in_scan),
        .in_last_in_scan          (sample_in.last_in_scan),
        .cfg_we                   (cfg.valid),
        .cfg_index                (cfg.index),
        .cfg_data                 (cfg.data),
        .out_ready                (result.ready),
        .out_valid                (result.valid),
        .out_sample_valid         (result.sample_valid),
        .out_inside_obstacle      (result.inside_obstacle),
        .out_obstacle_done        (result.obstacle_done),
        .out_obstacle_first_index (result.obstacle_first_index),
        .out_obstacle_last_index  (result.obstacle_last_index),
        .out_obstacle_mean_mm     (result.obstacle_mean_mm)
    );

    `LSOS_ASSERT_NOW(a_no_accept_in_clear, cmd.clear_step, !sample_in.ready, "accept during clear")
    `LSOS_ASSERT_NEXT(a_load_then_prep, cmd.load, !cmd.load && !cmd.fin, "load not followed by prep")
    `LSOS_ASSERT_NOW(a_result_from_fin, $rose(result.valid), $past(cmd.fin), "result without update")

endmodule
